/* rtl/rttc_pkg.sv */
// Shared constants, codes and payload types of the run-time clock block.
`default_nettype none

package rttc_pkg;

  localparam int COUNTER_BITS_DEF = 24;
  localparam int PRESCALER_W      = 12;
  localparam int TICK_NS_W        = 27;
  localparam int RT_W             = 32;
  localparam int NS_CARRY_W       = 20;
  localparam int MSIS_W           = 10;

  localparam int TICK_UNIT_NS    = 30517;
  localparam int NANOS_PER_MILLI = 1000000;
  localparam int MS_PER_S        = 1000;

  localparam logic [TICK_NS_W-1:0] TICK_NS_RESET = TICK_NS_W'(TICK_UNIT_NS);

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_SET_UTC = 1'b1
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [RT_W-1:0] utc_in;
    logic [RT_W-1:0] past;
  } samp_side_t;

  typedef struct packed {
    logic [RT_W-1:0] run;
    logic [RT_W-1:0] elapsed;
    logic [RT_W-1:0] base;
  } time_side_t;

  typedef struct packed {
    logic [RT_W-1:0]   run_ms;
    logic [RT_W-1:0]   elapsed_ms;
    logic [RT_W-1:0]   utc_seconds_now;
    logic [MSIS_W-1:0] ms_in_second;
  } res_t;

endpackage

`default_nettype wire

/* rtl/rttc_if.sv */
// Valid/ready channel interfaces for counter samples and run-time results.
`default_nettype none

interface rttc_in_if #(
  parameter int COUNTER_BITS = rttc_pkg::COUNTER_BITS_DEF
);
  import rttc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [0:0]              operation;
  logic [COUNTER_BITS-1:0] counter_value;
  logic [RT_W-1:0]         utc_seconds_in;
  logic [RT_W-1:0]         past_ms;

  modport source (
    output valid, operation, counter_value, utc_seconds_in, past_ms,
    input  ready
  );

  modport sink (
    input  valid, operation, counter_value, utc_seconds_in, past_ms,
    output ready
  );
endinterface

interface rttc_out_if;
  import rttc_pkg::*;

  logic              valid;
  logic              ready;
  logic [RT_W-1:0]   run_ms;
  logic [RT_W-1:0]   elapsed_ms;
  logic [RT_W-1:0]   utc_seconds_now;
  logic [MSIS_W-1:0] ms_in_second;

  modport source (
    output valid, run_ms, elapsed_ms, utc_seconds_now, ms_in_second,
    input  ready
  );

  modport sink (
    input  valid, run_ms, elapsed_ms, utc_seconds_now, ms_in_second,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/rtc_tick_to_run_time_clock.sv */
// Run-time millisecond clock driven by samples of a free-running RTC counter.
//
//   channel   role    handshake      payload
//   sample    sink    valid/ready    operation, counter_value, utc_seconds_in, past_ms
//   result    source  valid/ready    run_ms, elapsed_ms, utc_seconds_now, ms_in_second
//   cfg       write   cfg_we         cfg_wdata (tick prescaler)
//
// One item per cycle while the skid stage is empty; the path has 13 register stages: input,
// two five-stage reciprocal dividers, run-time accumulator and result register.
// Reset clears the counter history, run time, carry and UTC reference; prescaler is 0.
// A full skid stage behind the result register stalls the whole pipeline and drops
// sample.ready; the next item is still taken while one result waits.
`default_nettype none

module rtc_tick_to_run_time_clock #(
  parameter int COUNTER_BITS = rttc_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rttc_pkg::PRESCALER_W-1:0] cfg_wdata,
  rttc_in_if.sink                          sample,
  rttc_out_if.source                       result
);
  import rttc_pkg::*;

  localparam int NS_W = COUNTER_BITS + TICK_NS_W;
  localparam logic [NS_CARRY_W:0] NANOS_PER_MILLI_V = (NS_CARRY_W+1)'(NANOS_PER_MILLI);

  logic                    adv;
  logic [TICK_NS_W-1:0]    tick_ns;
  logic [COUNTER_BITS-1:0] last_counter;

  logic                    p_valid;
  logic [COUNTER_BITS-1:0] p_ticks;
  samp_side_t              p_side;

  logic                    d1_valid;
  logic [RT_W-1:0]         d1_quo;
  logic [NS_CARRY_W-1:0]   d1_rem;
  samp_side_t              d1_side;

  logic                    a_valid;
  logic [RT_W-1:0]         a_past;
  logic [RT_W-1:0]         run_time_ms;
  logic [NS_CARRY_W-1:0]   ns_carry;
  logic [RT_W-1:0]         utc_base_seconds;
  logic [RT_W-1:0]         run_ms_at_utc;

  logic [NS_CARRY_W:0]     carry_sum;
  logic                    carry_wrap;
  logic [NS_CARRY_W-1:0]   ns_carry_next;
  logic [RT_W-1:0]         run_time_ms_next;

  time_side_t              d2_side_in;
  logic                    d2_valid;
  logic [RT_W-1:0]         d2_quo;
  logic [MSIS_W-1:0]       d2_rem;
  time_side_t              d2_side;

  res_t                    pipe_res;
  logic                    out_valid;
  res_t                    out_data;
  logic                    skid_valid;
  res_t                    skid_data;

  assign adv          = !skid_valid;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ns <= TICK_NS_RESET;
    end else if (cfg_we) begin
      tick_ns <= TICK_NS_W'({1'b0, cfg_wdata} + 13'd1) * TICK_NS_W'(TICK_UNIT_NS);
    end
  end

  // take the counter difference at the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      last_counter <= '0;
    end else if (adv) begin
      p_valid <= sample.valid;
      if (sample.valid) begin
        last_counter <= sample.counter_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ticks <= sample.counter_value - last_counter;
      p_side  <= '{op:     op_t'(sample.operation),
                   utc_in: sample.utc_seconds_in,
                   past:   sample.past_ms};
    end
  end

  rttc_div #(
    .NUM_W  (NS_W),
    .DEN    (NANOS_PER_MILLI),
    .REM_W  (NS_CARRY_W),
    .QUO_W  (RT_W),
    .SIDE_W ($bits(samp_side_t))
  ) u_ns_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p_valid),
    .in_num    (NS_W'(p_ticks) * NS_W'(tick_ns)),
    .in_side   (p_side),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_rem   (d1_rem),
    .out_side  (d1_side)
  );

  always_comb begin
    carry_sum        = {1'b0, ns_carry} + {1'b0, d1_rem};
    carry_wrap       = carry_sum >= NANOS_PER_MILLI_V;
    ns_carry_next    = carry_wrap ? NS_CARRY_W'(carry_sum - NANOS_PER_MILLI_V)
                                  : carry_sum[NS_CARRY_W-1:0];
    run_time_ms_next = run_time_ms + d1_quo + RT_W'(carry_wrap);
  end

  // advance run time and capture the UTC reference
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid          <= 1'b0;
      run_time_ms      <= '0;
      ns_carry         <= '0;
      utc_base_seconds <= '0;
      run_ms_at_utc    <= '0;
    end else if (adv) begin
      a_valid <= d1_valid;
      if (d1_valid) begin
        run_time_ms <= run_time_ms_next;
        ns_carry    <= ns_carry_next;
        if (d1_side.op == OP_SET_UTC) begin
          utc_base_seconds <= d1_side.utc_in;
          run_ms_at_utc    <= run_time_ms_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_past <= d1_side.past;
    end
  end

  assign d2_side_in = '{run:     run_time_ms,
                        elapsed: run_time_ms - a_past,
                        base:    utc_base_seconds};

  rttc_div #(
    .NUM_W  (RT_W),
    .DEN    (MS_PER_S),
    .REM_W  (MSIS_W),
    .QUO_W  (RT_W),
    .SIDE_W ($bits(time_side_t))
  ) u_ms_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (a_valid),
    .in_num    (run_time_ms - run_ms_at_utc),
    .in_side   (d2_side_in),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_rem   (d2_rem),
    .out_side  (d2_side)
  );

  assign pipe_res = '{run_ms:          d2_side.run,
                      elapsed_ms:      d2_side.elapsed,
                      utc_seconds_now: d2_side.base + d2_quo,
                      ms_in_second:    d2_rem};

  // result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_valid || result.ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (d2_valid) begin
      if (!out_valid || result.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_valid || result.ready) begin
        out_data <= skid_data;
      end
    end else if (d2_valid) begin
      if (!out_valid || result.ready) begin
        out_data <= pipe_res;
      end else begin
        skid_data <= pipe_res;
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.run_ms          = out_data.run_ms;
  assign result.elapsed_ms      = out_data.elapsed_ms;
  assign result.utc_seconds_now = out_data.utc_seconds_now;
  assign result.ms_in_second    = out_data.ms_in_second;

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds an item while the result register is empty");

  a_carry_bound: assert property (@(posedge clk) disable iff (rst)
    ns_carry < NS_CARRY_W'(NANOS_PER_MILLI))
    else $error("nanosecond carry reached one millisecond");

  a_last_counter: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(sample.valid && sample.ready))
      |-> last_counter == $past(sample.counter_value))
    else $error("counter history does not follow the accepted item");

  a_ms_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.ms_in_second < MSIS_W'(MS_PER_S))
    else $error("milliseconds within second out of range");

endmodule

`default_nettype wire

/* rtl/rttc_div.sv */
// Pipelined divider by a constant: reciprocal multiply, then one correction step.
`default_nettype none

module rttc_div #(
  parameter int NUM_W  = rttc_pkg::RT_W,
  parameter int DEN    = rttc_pkg::MS_PER_S,
  parameter int REM_W  = rttc_pkg::MSIS_W,
  parameter int QUO_W  = rttc_pkg::RT_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [REM_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  localparam int LIMB_W = 32;
  localparam int WIDE_W = 2 * LIMB_W;
  localparam int RW     = REM_W + 1;
  localparam logic [WIDE_W:0]   POW_K = (WIDE_W+1)'(1) << NUM_W;
  localparam logic [WIDE_W-1:0] RECIP = WIDE_W'(POW_K / (WIDE_W+1)'(DEN));
  localparam logic [RW-1:0]     DEN_V = RW'(DEN);

  logic                v0;
  logic                v1;
  logic                v2;
  logic                v3;
  logic                v4;
  logic [WIDE_W-1:0]   num0;
  logic [SIDE_W-1:0]   side0;
  logic [SIDE_W-1:0]   side1;
  logic [SIDE_W-1:0]   side2;
  logic [SIDE_W-1:0]   side3;
  logic [SIDE_W-1:0]   side4;
  logic [WIDE_W-1:0]   pp_ll;
  logic [WIDE_W-1:0]   pp_lh;
  logic [WIDE_W-1:0]   pp_hl;
  logic [WIDE_W-1:0]   pp_hh;
  logic [RW-1:0]       nlo1;
  logic [RW-1:0]       nlo2;
  logic [QUO_W-1:0]    qe2;
  logic [QUO_W-1:0]    qe3;
  logic [RW-1:0]       r3;
  logic [QUO_W-1:0]    quo4;
  logic [REM_W-1:0]    rem4;
  logic [WIDE_W:0]     pp_mid;
  logic [2*WIDE_W-1:0] prod_sum;
  logic [RW-1:0]       qd_lo;
  logic                r_ge;

  always_comb begin
    pp_mid   = {1'b0, pp_lh} + {1'b0, pp_hl};
    prod_sum = {pp_hh, pp_ll} + ((2*WIDE_W)'(pp_mid) << LIMB_W);
    qd_lo    = RW'(qe2) * DEN_V;
    r_ge     = r3 >= DEN_V;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // estimate is the quotient or one below; the remainder check settles it
  always_ff @(posedge clk) begin
    if (adv) begin
      num0  <= WIDE_W'(in_num);
      side0 <= in_side;

      pp_ll <= WIDE_W'(num0[LIMB_W-1:0]) * WIDE_W'(RECIP[LIMB_W-1:0]);
      pp_lh <= WIDE_W'(num0[LIMB_W-1:0]) * WIDE_W'(RECIP[WIDE_W-1:LIMB_W]);
      pp_hl <= WIDE_W'(num0[WIDE_W-1:LIMB_W]) * WIDE_W'(RECIP[LIMB_W-1:0]);
      pp_hh <= WIDE_W'(num0[WIDE_W-1:LIMB_W]) * WIDE_W'(RECIP[WIDE_W-1:LIMB_W]);
      nlo1  <= num0[RW-1:0];
      side1 <= side0;

      qe2   <= QUO_W'(prod_sum >> NUM_W);
      nlo2  <= nlo1;
      side2 <= side1;

      qe3   <= qe2;
      r3    <= nlo2 - qd_lo;
      side3 <= side2;

      quo4  <= qe3 + QUO_W'(r_ge);
      rem4  <= REM_W'(r_ge ? r3 - DEN_V : r3);
      side4 <= side3;
    end
  end

  assign out_valid = v4;
  assign out_quo   = quo4;
  assign out_rem   = rem4;
  assign out_side  = side4;

endmodule

`default_nettype wire
